// ===== hw/rtl/sgpg_pkg.sv =====
package sgpg_pkg;

   localparam int IMAGE_WIDTH_DEF    = 256;
   localparam int IMAGE_HEIGHT_DEF   = 256;
   localparam int COS_TABLE_BITS_DEF = 10;

   localparam int PIXEL_W      = 8;
   localparam int FRAME_W      = 16;
   localparam int LEVEL_W      = 16;
   localparam int PHASE_W      = 16;
   localparam int WORD_W       = 48;
   localparam int STORE_ADDR_W = 2 * PIXEL_W;
   localparam int STORE_DEPTH  = 1 << STORE_ADDR_W;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 48;
   localparam int COS_W        = 17;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned SERIES_DIV [7] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                                  64'd90, 64'd132, 64'd182};

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_GRATING_MODE   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WINDOWS  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MEAN_LEVEL     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_AMPLITUDE      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SPATIAL_STEPS  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_TIME_PHASES    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_COLOUR_GAINS   = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_CHANNEL_PHASES = 3'd7;

   // grating modes
   localparam logic [1:0] MODE_DRIFT   = 2'd0;
   localparam logic [1:0] MODE_COUNTER = 2'd1;
   localparam logic [1:0] MODE_STATIC  = 2'd2;

   // what a pixel transaction does
   localparam logic [1:0] KIND_BACKGROUND = 2'd0;
   localparam logic [1:0] KIND_GRATING    = 2'd1;
   localparam logic [1:0] KIND_REVERSED   = 2'd2;
   localparam logic [1:0] KIND_HOLD       = 2'd3;

   localparam logic [LEVEL_W-1:0] MEAN_LEVEL_RESET = 16'd256;

   typedef struct packed {
      logic [1:0]  grating_mode;
      logic [47:0] frame_windows;
      logic [15:0] mean_level;
      logic [15:0] amplitude;
      logic [31:0] spatial_steps;
      logic [47:0] time_phases;
      logic [47:0] colour_gains;
      logic [47:0] channel_phases;
   } cfg_type;

   typedef struct packed {
      logic [1:0]              kind;
      logic                    counter;
      logic [STORE_ADDR_W-1:0] addr;
   } item_ctrl_type;

   // quarter-wave cosine entry, Q1.15, evaluated at elaboration only
   function automatic logic [15:0] quarter_entry(input longint unsigned i,
                                                 input int unsigned bits);
      longint unsigned n;
      longint unsigned a;
      longint unsigned a2;
      longint unsigned term;
      longint          sum;
      logic [15:0]     res;
      n = 64'd1 << bits;
      res = '0;
      if (i < n) begin
         a = (HALF_PI_Q30 * i) >> bits;
         a2 = (a * a) >> 30;
         term = 64'd1 << 30;
         sum = longint'(term);
         for (int k = 1; k <= 7; k++) begin
            term = ((term * a2) >> 30) / SERIES_DIV[k-1];
            if ((k % 2) == 1) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         res = 16'((sum + 64'sd16384) >>> 15);
      end
      return res;
   endfunction

endpackage

// ===== hw/rtl/sgpg_ram.sv =====
module sgpg_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/sgpg_phase.sv =====
module sgpg_phase import sgpg_pkg::*; #(
   parameter int IMAGE_WIDTH  = IMAGE_WIDTH_DEF,
   parameter int IMAGE_HEIGHT = IMAGE_HEIGHT_DEF
) (
   input  logic                      clock,
   input  logic                      load_1,
   input  logic                      load_2,
   input  cfg_type                   cfg,
   input  logic [FRAME_W-1:0]        frame_index,
   input  logic [PIXEL_W-1:0]        pixel_x,
   input  logic [PIXEL_W-1:0]        pixel_y,
   output item_ctrl_type             ctrl_1,
   output logic [2:0][PHASE_W-1:0]   chan_phase,
   output logic [PHASE_W-1:0]        time_phase
);

   localparam int HALF_X   = IMAGE_HEIGHT / 2;
   localparam int HALF_Y   = IMAGE_WIDTH / 2;
   localparam int HALF_MAX = (HALF_X > HALF_Y) ? HALF_X : HALF_Y;
   localparam int HALF_W   = $clog2(HALF_MAX + 1);
   localparam int DELTA_W  = ((HALF_W > PIXEL_W) ? HALF_W : PIXEL_W) + 1;

   logic signed [DELTA_W-1:0]    dx;
   logic signed [DELTA_W-1:0]    dy;
   logic signed [DELTA_W+15:0]   prod_x;
   logic signed [DELTA_W+15:0]   prod_y;
   logic [31:0]                  drift_full;
   logic [15:0]                  bg_len;
   logic [16:0]                  end1;
   logic [17:0]                  end2;
   item_ctrl_type                ctrl_in;
   logic                         drift_sub_in;
   logic [PHASE_W-1:0]           spatial;
   logic [2:0][PHASE_W-1:0]      chan_phase_in;
   logic [PHASE_W-1:0]           time_phase_in;

   item_ctrl_type                ctrl_ff;
   logic                         drift_sub_ff;
   logic [PHASE_W-1:0]           dxcx_ff;
   logic [PHASE_W-1:0]           dycy_ff;
   logic [PHASE_W-1:0]           drift_ff;
   logic [2:0][PHASE_W-1:0]      chan_phase_ff;
   logic [PHASE_W-1:0]           time_phase_ff;

   // window decode and the three products
   always_comb begin
      dx = $signed(DELTA_W'(pixel_x)) - $signed(DELTA_W'(HALF_X));
      dy = $signed(DELTA_W'(pixel_y)) - $signed(DELTA_W'(HALF_Y));
      prod_x = dx * $signed(cfg.spatial_steps[15:0]);
      prod_y = dy * $signed(cfg.spatial_steps[31:16]);
      drift_full = cfg.time_phases[15:0] * frame_index;

      bg_len = cfg.frame_windows[15:0];
      end1 = 17'(bg_len) + 17'(cfg.frame_windows[31:16]);
      end2 = 18'(end1);
      if (cfg.grating_mode == MODE_STATIC) begin
         end2 = 18'(end1) + 18'(cfg.frame_windows[47:32]);
      end

      ctrl_in.addr = {pixel_y, pixel_x};
      if (frame_index < bg_len) begin
         ctrl_in.kind = KIND_BACKGROUND;
      end else if (17'(frame_index) < end1) begin
         ctrl_in.kind = KIND_GRATING;
      end else if (18'(frame_index) < end2) begin
         ctrl_in.kind = KIND_REVERSED;
      end else begin
         ctrl_in.kind = KIND_HOLD;
      end
      ctrl_in.counter = (ctrl_in.kind == KIND_GRATING) &&
                        (cfg.grating_mode == MODE_COUNTER);
      drift_sub_in = (ctrl_in.kind == KIND_GRATING) &&
                     (cfg.grating_mode == MODE_DRIFT);
   end

   always_ff @(posedge clock) begin
      if (load_1) begin
         ctrl_ff      <= ctrl_in;
         drift_sub_ff <= drift_sub_in;
         dxcx_ff      <= prod_x[PHASE_W-1:0];
         dycy_ff      <= prod_y[PHASE_W-1:0];
         drift_ff     <= drift_full[PHASE_W-1:0];
      end
   end

   // phase sums, all mod one turn
   always_comb begin
      spatial = 16'(dxcx_ff + dycy_ff + cfg.time_phases[31:16]);
      if (drift_sub_ff) begin
         spatial = 16'(spatial - drift_ff);
      end
      for (int c = 0; c < 3; c++) begin
         chan_phase_in[c] = 16'(spatial + cfg.channel_phases[16*c +: 16]);
      end
      time_phase_in = 16'(drift_ff + cfg.time_phases[47:32]);
   end

   always_ff @(posedge clock) begin
      if (load_2) begin
         chan_phase_ff <= chan_phase_in;
         time_phase_ff <= time_phase_in;
      end
   end

   assign ctrl_1     = ctrl_ff;
   assign chan_phase = chan_phase_ff;
   assign time_phase = time_phase_ff;

endmodule

// ===== hw/rtl/sgpg_cos.sv =====
module sgpg_cos import sgpg_pkg::*; #(
   parameter int TABLE_BITS = COS_TABLE_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    load_a,
   input  logic                    load_b,
   input  logic [PHASE_W-1:0]      phase,
   output logic signed [COS_W-1:0] cos_value
);

   localparam int N = 1 << TABLE_BITS;

   typedef logic [15:0] cos_table_type [N];

   function automatic cos_table_type build_table();
      cos_table_type tbl;
      for (int i = 0; i < N; i++) begin
         tbl[i] = quarter_entry(longint'(i), TABLE_BITS);
      end
      return tbl;
   endfunction

   localparam cos_table_type COS_TABLE = build_table();

   logic [TABLE_BITS+1:0]   idx;
   logic [1:0]              quad;
   logic [TABLE_BITS-1:0]   low;
   logic [TABLE_BITS-1:0]   tidx_in;
   logic                    zero_in;
   logic                    neg_in;
   logic [15:0]             mag;

   logic [TABLE_BITS-1:0]   tidx_ff;
   logic                    zero_ff;
   logic                    neg_ff;
   logic signed [COS_W-1:0] cos_value_ff;

   // quadrant fold onto the quarter wave
   always_comb begin
      idx = phase[PHASE_W-1 -: TABLE_BITS+2];
      quad = idx[TABLE_BITS+1:TABLE_BITS];
      low = idx[TABLE_BITS-1:0];
      tidx_in = low;
      zero_in = 1'b0;
      if (quad[0]) begin
         tidx_in = TABLE_BITS'(~low + 1'b1);
         zero_in = (low == '0);
      end
      neg_in = (quad == 2'd1) || (quad == 2'd2);
   end

   always_ff @(posedge clock) begin
      if (load_a) begin
         tidx_ff <= tidx_in;
         zero_ff <= zero_in;
         neg_ff  <= neg_in;
      end
   end

   always_comb begin
      mag = zero_ff ? 16'd0 : COS_TABLE[tidx_ff];
   end

   always_ff @(posedge clock) begin
      if (load_b) begin
         cos_value_ff <= neg_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      end
   end

   assign cos_value = cos_value_ff;

endmodule

// ===== hw/rtl/sgpg_chan.sv =====
module sgpg_chan import sgpg_pkg::*; (
   input  logic                    clock,
   input  logic                    load_5,
   input  logic                    load_6,
   input  logic                    load_7,
   input  item_ctrl_type           ctrl_4,
   input  logic signed [COS_W-1:0] cos_value,
   input  logic signed [COS_W-1:0] time_cos,
   input  logic [LEVEL_W-1:0]      gain,
   input  logic [LEVEL_W-1:0]      mean_level,
   input  logic [LEVEL_W-1:0]      amplitude,
   output logic [LEVEL_W-1:0]      value
);

   logic signed [2*COS_W-1:0] cp_prod;
   logic signed [2*COS_W-1:0] cp_round;
   logic signed [COS_W-1:0]   c_sel;
   logic signed [COS_W-1:0]   c_in;
   logic signed [49:0]        amp_prod_in;
   logic signed [50:0]        level_sum;
   logic signed [20:0]        level_q;
   logic [LEVEL_W-1:0]        value_in;

   logic [31:0]               ga_ff;
   logic [31:0]               gl_ff;
   logic signed [COS_W-1:0]   c_ff;
   logic signed [49:0]        amp_prod_ff;
   logic [LEVEL_W-1:0]        value_ff;

   // gain products follow the registers
   always_ff @(posedge clock) begin
      ga_ff <= gain * amplitude;
      gl_ff <= gain * mean_level;
   end

   always_comb begin
      cp_prod = cos_value * time_cos;
      cp_round = cp_prod + 34'sd16384;
      c_sel = ctrl_4.counter ? cp_round[COS_W+14:15] : cos_value;
      case (ctrl_4.kind)
         KIND_BACKGROUND: c_in = '0;
         KIND_REVERSED:   c_in = -c_sel;
         default:         c_in = c_sel;
      endcase
   end

   always_ff @(posedge clock) begin
      if (load_5) begin
         c_ff <= c_in;
      end
   end

   always_comb begin
      amp_prod_in = $signed({1'b0, ga_ff}) * c_ff;
   end

   always_ff @(posedge clock) begin
      if (load_6) begin
         amp_prod_ff <= amp_prod_in;
      end
   end

   // round half up to q8.8 and saturate
   always_comb begin
      level_sum = $signed({4'b0, gl_ff, 15'b0}) + $signed({amp_prod_ff[49], amp_prod_ff})
                + 51'sd536870912;
      level_q = level_sum[50:30];
      if (level_q > 21'sd32767) begin
         value_in = 16'h7fff;
      end else if (level_q < -21'sd32768) begin
         value_in = 16'h8000;
      end else begin
         value_in = level_q[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load_7) begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

// ===== hw/rtl/sinusoidal_grating_pixel_generator.sv =====
// throughput: one pixel per cycle while the output is not stalled; seven compute
//   stages and an output register, the frame store is written or read once per pixel
//   on its one port pair
// reset: synchronous, clears control state and loads register defaults, then a pass over
//   all 65536 addresses zeroes the frame store with req_ready low; csr writes are taken
module sinusoidal_grating_pixel_generator import sgpg_pkg::*; #(
   parameter int IMAGE_WIDTH    = IMAGE_WIDTH_DEF,
   parameter int IMAGE_HEIGHT   = IMAGE_HEIGHT_DEF,
   parameter int COS_TABLE_BITS = COS_TABLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [FRAME_W-1:0]     req_frame_index,
   input  logic [PIXEL_W-1:0]     req_pixel_x,
   input  logic [PIXEL_W-1:0]     req_pixel_y,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [LEVEL_W-1:0]     rsp_red_value,
   output logic [LEVEL_W-1:0]     rsp_green_value,
   output logic [LEVEL_W-1:0]     rsp_blue_value,
   output logic                   rsp_freshly_computed,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type                   cfg_ff;
   cfg_type                   cfg_in;

   logic [8:1]                load;
   logic [7:1]                vld_ff;
   logic [7:1]                vld_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   item_ctrl_type             ctrl_ff [2:7];
   item_ctrl_type             stage_ctrl [1:7];
   item_ctrl_type             ctrl_1;

   logic [STORE_ADDR_W-1:0]   clear_addr_ff;
   logic                      clear_done_ff;

   logic [2:0][PHASE_W-1:0]   chan_phase;
   logic [PHASE_W-1:0]        time_phase;
   logic signed [COS_W-1:0]   chan_cos [3];
   logic signed [COS_W-1:0]   time_cos;
   logic [2:0][LEVEL_W-1:0]   chan_value;

   logic                      mem_go;
   logic                      mem_wr;
   logic                      ram_wr_en;
   logic [STORE_ADDR_W-1:0]   ram_wr_addr;
   logic [WORD_W-1:0]         ram_wr_data;
   logic                      ram_rd_en;
   logic [WORD_W-1:0]         ram_rd_data;

   logic [WORD_W-1:0]         rsp_word_ff;
   logic                      rsp_fresh_ff;
   logic [WORD_W-1:0]         rsp_word;

   // register file
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_GRATING_MODE:   cfg_in.grating_mode   = csr_data[1:0];
            REG_FRAME_WINDOWS:  cfg_in.frame_windows  = csr_data[47:0];
            REG_MEAN_LEVEL:     cfg_in.mean_level     = csr_data[15:0];
            REG_AMPLITUDE:      cfg_in.amplitude      = csr_data[15:0];
            REG_SPATIAL_STEPS:  cfg_in.spatial_steps  = csr_data[31:0];
            REG_TIME_PHASES:    cfg_in.time_phases    = csr_data[47:0];
            REG_COLOUR_GAINS:   cfg_in.colour_gains   = csr_data[47:0];
            REG_CHANNEL_PHASES: cfg_in.channel_phases = csr_data[47:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff            <= '0;
         cfg_ff.mean_level <= MEAN_LEVEL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;

   // pipeline flow control
   always_comb begin
      load[8] = !rsp_valid_ff || rsp_ready;
      for (int k = 7; k >= 1; k--) begin
         load[k] = !vld_ff[k] || load[k+1];
      end
      vld_in[1] = load[1] ? (req_valid && clear_done_ff) : vld_ff[1];
      for (int k = 2; k <= 7; k++) begin
         vld_in[k] = load[k] ? vld_ff[k-1] : vld_ff[k];
      end
      rsp_valid_in = load[8] ? vld_ff[7] : rsp_valid_ff;
   end

   assign req_ready = load[1] && clear_done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      stage_ctrl[1] = ctrl_1;
      for (int k = 2; k <= 7; k++) begin
         stage_ctrl[k] = ctrl_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 2; k <= 7; k++) begin
         if (load[k]) begin
            ctrl_ff[k] <= stage_ctrl[k-1];
         end
      end
   end

   // store clearing after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff <= '0;
         clear_done_ff <= 1'b0;
      end else if (!clear_done_ff) begin
         clear_addr_ff <= clear_addr_ff + 1'b1;
         clear_done_ff <= (clear_addr_ff == '1);
      end
   end

   sgpg_phase #(
      .IMAGE_WIDTH  (IMAGE_WIDTH),
      .IMAGE_HEIGHT (IMAGE_HEIGHT)
   ) u_phase (
      .clock       (clock),
      .load_1      (load[1]),
      .load_2      (load[2]),
      .cfg         (cfg_ff),
      .frame_index (req_frame_index),
      .pixel_x     (req_pixel_x),
      .pixel_y     (req_pixel_y),
      .ctrl_1      (ctrl_1),
      .chan_phase  (chan_phase),
      .time_phase  (time_phase)
   );

   sgpg_cos #(
      .TABLE_BITS (COS_TABLE_BITS)
   ) u_cos_time (
      .clock     (clock),
      .load_a    (load[3]),
      .load_b    (load[4]),
      .phase     (time_phase),
      .cos_value (time_cos)
   );

   for (genvar c = 0; c < 3; c++) begin : g_chan
      sgpg_cos #(
         .TABLE_BITS (COS_TABLE_BITS)
      ) u_cos (
         .clock     (clock),
         .load_a    (load[3]),
         .load_b    (load[4]),
         .phase     (chan_phase[c]),
         .cos_value (chan_cos[c])
      );

      sgpg_chan u_chan (
         .clock      (clock),
         .load_5     (load[5]),
         .load_6     (load[6]),
         .load_7     (load[7]),
         .ctrl_4     (stage_ctrl[4]),
         .cos_value  (chan_cos[c]),
         .time_cos   (time_cos),
         .gain       (cfg_ff.colour_gains[16*c +: 16]),
         .mean_level (cfg_ff.mean_level),
         .amplitude  (cfg_ff.amplitude),
         .value      (chan_value[c])
      );
   end

   // frame store access as a transaction leaves the last stage
   always_comb begin
      mem_go = load[8] && vld_ff[7];
      mem_wr = mem_go && (stage_ctrl[7].kind != KIND_HOLD);
      ram_rd_en = mem_go && (stage_ctrl[7].kind == KIND_HOLD);
      ram_wr_en = !clear_done_ff || mem_wr;
      ram_wr_addr = clear_done_ff ? stage_ctrl[7].addr : clear_addr_ff;
      ram_wr_data = clear_done_ff ? chan_value : '0;
   end

   sgpg_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (stage_ctrl[7].addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (load[8]) begin
         rsp_word_ff  <= chan_value;
         rsp_fresh_ff <= (stage_ctrl[7].kind != KIND_HOLD);
      end
   end

   assign rsp_word             = rsp_fresh_ff ? rsp_word_ff : ram_rd_data;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_red_value        = rsp_word[15:0];
   assign rsp_green_value      = rsp_word[31:16];
   assign rsp_blue_value       = rsp_word[47:32];
   assign rsp_freshly_computed = rsp_fresh_ff;

`ifndef SYNTHESIS
   a_store_port_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("frame store written and read in one cycle");

   a_empty_while_clearing: assert property (@(posedge clock) disable iff (reset)
      !clear_done_ff |-> (vld_ff == '0) && !rsp_valid_ff)
      else $error("transaction in flight during store clearing");

   a_held_reaches_output: assert property (@(posedge clock) disable iff (reset)
      ram_rd_en |=> rsp_valid && !rsp_freshly_computed)
      else $error("held pixel did not reach the output");

   a_fresh_reaches_output: assert property (@(posedge clock) disable iff (reset)
      mem_wr |=> rsp_valid && rsp_freshly_computed)
      else $error("computed pixel did not reach the output");
`endif

endmodule

// ===== tb/sv/sinusoidal_grating_pixel_generator_test.sv =====
module sinusoidal_grating_pixel_generator_test;
   timeunit 1ns;
   timeprecision 1ps;

   import sgpg_pkg::*;

   localparam int COS_BITS = COS_TABLE_BITS_DEF;
   localparam int QUARTER_N = 1 << COS_BITS;
   localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
   localparam logic [1:0] MODE_STATIC_ONLY = 2'd3;
   localparam int QUIET_LIMIT = 300000;
   localparam int DRAIN_TAIL = 24;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int MAX_PRINTED = 40;

   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic        fresh;
   } pixel_result_t;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [FRAME_W-1:0]     req_frame_index = '0;
   logic [PIXEL_W-1:0]     req_pixel_x = '0;
   logic [PIXEL_W-1:0]     req_pixel_y = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [LEVEL_W-1:0]     rsp_red_value;
   logic [LEVEL_W-1:0]     rsp_green_value;
   logic [LEVEL_W-1:0]     rsp_blue_value;
   logic                   rsp_freshly_computed;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   cfg_type       model_cfg;
   logic [47:0]   pixel_store [int];
   int            quarter_wave [0:QUARTER_N];
   pixel_result_t expected_pixels [$];
   int            pixels_sent = 0;
   int            results_checked = 0;
   int            error_count = 0;
   int            settings_written = 0;
   int            kind_count [4] = '{0, 0, 0, 0};
   int            send_idle_pct = 0;
   int            stall_pct = 0;
   int            holdoff_left = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   sinusoidal_grating_pixel_generator dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_frame_index      (req_frame_index),
      .req_pixel_x          (req_pixel_x),
      .req_pixel_y          (req_pixel_y),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_red_value        (rsp_red_value),
      .rsp_green_value      (rsp_green_value),
      .rsp_blue_value       (rsp_blue_value),
      .rsp_freshly_computed (rsp_freshly_computed),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   function automatic int cos_lookup(logic [15:0] phase);
      logic [COS_BITS+1:0] idx;
      int                  i;
      idx = phase[15 -: COS_BITS+2];
      i = int'(idx[COS_BITS-1:0]);
      case (idx[COS_BITS+1:COS_BITS])
         2'd0: return quarter_wave[i];
         2'd1: return -quarter_wave[QUARTER_N - i];
         2'd2: return -quarter_wave[i];
         default: return quarter_wave[QUARTER_N - i];
      endcase
   endfunction

   function automatic logic [15:0] channel_level(logic [15:0] gain, int c, bit negate);
      longint lum;
      longint swing;
      longint v;
      lum = longint'(gain) * longint'(model_cfg.mean_level) * 32768;
      swing = longint'(gain) * longint'(model_cfg.amplitude) * longint'(c);
      v = negate ? lum - swing : lum + swing;
      v = (v + (longint'(1) <<< 29)) >>> 30;
      if (v > 32767) begin
         v = 32767;
      end else if (v < -32768) begin
         v = -32768;
      end
      return v[15:0];
   endfunction

   function automatic pixel_result_t render_pixel(logic [15:0] t, logic [7:0] x,
                                                  logic [7:0] y);
      int            addr;
      int            bg_end;
      int            first_end;
      int            last_end;
      int            dx;
      int            dy;
      int            c;
      int            ct;
      logic [15:0]   s;
      logic [15:0]   drift;
      logic [47:0]   word;
      bit            first;
      bit            counter;
      pixel_result_t r;
      addr = int'({y, x});
      bg_end = int'(model_cfg.frame_windows[15:0]);
      first_end = bg_end + int'(model_cfg.frame_windows[31:16]);
      last_end = first_end + ((model_cfg.grating_mode == MODE_STATIC) ?
                              int'(model_cfg.frame_windows[47:32]) : 0);
      word = '0;
      r.fresh = 1'b1;
      if (int'(t) < bg_end) begin
         for (int ch = 0; ch < 3; ch++) begin
            word[16*ch +: 16] = channel_level(model_cfg.colour_gains[16*ch +: 16], 0, 1'b0);
         end
         kind_count[KIND_BACKGROUND]++;
         pixel_store[addr] = word;
      end else if (int'(t) < last_end) begin
         first = int'(t) < first_end;
         counter = first && (model_cfg.grating_mode == MODE_COUNTER);
         dx = int'(x) - IMAGE_HEIGHT_DEF / 2;
         dy = int'(y) - IMAGE_WIDTH_DEF / 2;
         drift = model_cfg.time_phases[15:0] * t;
         s = 16'(dx * int'($signed(model_cfg.spatial_steps[15:0]))
                 + dy * int'($signed(model_cfg.spatial_steps[31:16])));
         s = s + model_cfg.time_phases[31:16];
         if (first && model_cfg.grating_mode == MODE_DRIFT) begin
            s = s - drift;
         end
         ct = counter ? cos_lookup(drift + model_cfg.time_phases[47:32]) : 32768;
         for (int ch = 0; ch < 3; ch++) begin
            c = cos_lookup(s + model_cfg.channel_phases[16*ch +: 16]);
            if (counter) begin
               c = int'((longint'(c) * ct + 16384) >>> 15);
            end
            word[16*ch +: 16] = channel_level(model_cfg.colour_gains[16*ch +: 16], c, !first);
         end
         kind_count[first ? KIND_GRATING : KIND_REVERSED]++;
         pixel_store[addr] = word;
      end else begin
         word = pixel_store.exists(addr) ? pixel_store[addr] : '0;
         r.fresh = 1'b0;
         kind_count[KIND_HOLD]++;
      end
      r.red = word[15:0];
      r.green = word[31:16];
      r.blue = word[47:32];
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_PRINTED) begin
         $display("ERROR %0t: %s", $time, what);
      end
   endtask

   always @(posedge clock) begin : scoreboard
      pixel_result_t got;
      pixel_result_t want;
      if (reset) begin
         model_cfg = '0;
         model_cfg.mean_level = MEAN_LEVEL_RESET;
         pixel_store.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.red = rsp_red_value;
            got.green = rsp_green_value;
            got.blue = rsp_blue_value;
            got.fresh = rsp_freshly_computed;
            if (expected_pixels.size() == 0) begin
               report_mismatch($sformatf("unexpected result %h %h %h fresh %b",
                                         got.red, got.green, got.blue, got.fresh));
            end else begin
               want = expected_pixels.pop_front();
               if (got !== want) begin
                  report_mismatch($sformatf(
                     "pixel %0d: got %h %h %h fresh %b, expected %h %h %h fresh %b",
                     results_checked, got.red, got.green, got.blue, got.fresh,
                     want.red, want.green, want.blue, want.fresh));
               end
               results_checked++;
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_GRATING_MODE:   model_cfg.grating_mode = csr_data[1:0];
               REG_FRAME_WINDOWS:  model_cfg.frame_windows = csr_data;
               REG_MEAN_LEVEL:     model_cfg.mean_level = csr_data[15:0];
               REG_AMPLITUDE:      model_cfg.amplitude = csr_data[15:0];
               REG_SPATIAL_STEPS:  model_cfg.spatial_steps = csr_data[31:0];
               REG_TIME_PHASES:    model_cfg.time_phases = csr_data;
               REG_COLOUR_GAINS:   model_cfg.colour_gains = csr_data;
               REG_CHANNEL_PHASES: model_cfg.channel_phases = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            expected_pixels.push_back(render_pixel(req_frame_index, req_pixel_x, req_pixel_y));
         end
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (holdoff_left > 0) begin
         rsp_ready <= 1'b0;
         holdoff_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("ERROR: no transaction for %0d cycles", QUIET_LIMIT);
      $display("FAILED: results differ");
      $finish;
   end

   task automatic send_pixel(input logic [15:0] frame, input logic [7:0] x,
                             input logic [7:0] y);
      int gap;
      gap = 0;
      while (gap < 30 && $urandom_range(99) < send_idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_frame_index <= frame;
      req_pixel_x <= x;
      req_pixel_y <= y;
      do @(posedge clock); while (req_ready !== 1'b1);
      pixels_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (results_checked < pixels_sent) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
   endtask

   task automatic apply_settings(input cfg_type s);
      drain_results();
      write_register(REG_GRATING_MODE, 48'(s.grating_mode));
      write_register(REG_FRAME_WINDOWS, s.frame_windows);
      write_register(REG_MEAN_LEVEL, 48'(s.mean_level));
      write_register(REG_AMPLITUDE, 48'(s.amplitude));
      write_register(REG_SPATIAL_STEPS, 48'(s.spatial_steps));
      write_register(REG_TIME_PHASES, s.time_phases);
      write_register(REG_COLOUR_GAINS, s.colour_gains);
      write_register(REG_CHANNEL_PHASES, s.channel_phases);
      csr_valid <= 1'b0;
      settings_written++;
   endtask

   // default registers leave every frame outside the windows, store is cleared
   task automatic test_reset_state();
      send_pixel(16'd0, 8'd0, 8'd0);
      send_pixel(16'hFFFF, 8'hFF, 8'hFF);
      send_pixel(16'h5A5A, 8'hA5, 8'h3C);
   endtask

   task automatic test_background_and_reversal();
      cfg_type s;
      s.grating_mode = MODE_STATIC;
      s.frame_windows = 48'h0004_0004_0004;
      s.mean_level = 16'hFFFF;
      s.amplitude = 16'hFFFF;
      s.spatial_steps = 32'h7FFF_8000;
      s.time_phases = 48'h1234_4000_0100;
      s.colour_gains = 48'h0000_8000_FFFF;
      s.channel_phases = 48'hFFFF_4000_0000;
      apply_settings(s);
      send_pixel(16'd0, 8'd0, 8'd0);
      send_pixel(16'd3, 8'd255, 8'd255);
      send_pixel(16'd4, 8'd0, 8'd0);
      send_pixel(16'd7, 8'd255, 8'd255);
      send_pixel(16'd6, 8'd128, 8'd128);
      send_pixel(16'd8, 8'd0, 8'd0);
      send_pixel(16'd11, 8'd255, 8'd255);
      send_pixel(16'd12, 8'd0, 8'd0);
      send_pixel(16'hFFFF, 8'd255, 8'd255);
   endtask

   task automatic test_counterphase();
      cfg_type s;
      s.grating_mode = MODE_COUNTER;
      s.frame_windows = 48'h0000_FFFF_0000;
      s.mean_level = 16'h0100;
      s.amplitude = 16'h4000;
      s.spatial_steps = 32'h0100_0200;
      s.time_phases = 48'h2000_0000_0400;
      s.colour_gains = 48'h7FFF_7FFF_7FFF;
      s.channel_phases = 48'h5555_AAAA_0000;
      apply_settings(s);
      send_pixel(16'd0, 8'd64, 8'd32);
      send_pixel(16'd1, 8'd200, 8'd10);
      send_pixel(16'h4000, 8'd128, 8'd128);
      send_pixel(16'hFFFE, 8'd3, 8'd250);
   endtask

   // window ends past the last frame, static grating without a reversed window
   task automatic test_window_overflow();
      cfg_type s;
      s.grating_mode = MODE_STATIC_ONLY;
      s.frame_windows = 48'hFFFF_FFFF_FFFF;
      s.mean_level = 16'h0000;
      s.amplitude = 16'hFFFF;
      s.spatial_steps = 32'h0000_0000;
      s.time_phases = 48'h0000_8000_0000;
      s.colour_gains = 48'hFFFF_FFFF_FFFF;
      s.channel_phases = 48'h0000_0000_0000;
      apply_settings(s);
      send_pixel(16'hFFFE, 8'd1, 8'd2);
      send_pixel(16'hFFFF, 8'd1, 8'd2);
   endtask

   task automatic test_drift_and_hold();
      cfg_type s;
      s.grating_mode = MODE_DRIFT;
      s.frame_windows = 48'h0007_0005_0000;
      s.mean_level = 16'h8000;
      s.amplitude = 16'h2000;
      s.spatial_steps = 32'hFF00_0080;
      s.time_phases = 48'h0000_0000_0800;
      s.colour_gains = 48'h4000_2000_1000;
      s.channel_phases = 48'h0000_0000_0000;
      apply_settings(s);
      send_pixel(16'd2, 8'd10, 8'd20);
      send_pixel(16'd4, 8'd10, 8'd20);
      send_pixel(16'd5, 8'd10, 8'd20);
      send_pixel(16'd6, 8'd30, 8'd40);
   endtask

   task automatic test_random_settings();
      cfg_type     s;
      int          span;
      logic [15:0] t;
      logic [7:0]  x;
      logic [7:0]  y;
      for (int phase = 0; phase < 8; phase++) begin
         s.grating_mode = 2'($urandom_range(0, 3));
         span = 16;
         for (int w = 0; w < 3; w++) begin
            if (phase >= 6) begin
               s.frame_windows[16*w +: 16] = 16'($urandom);
            end else begin
               s.frame_windows[16*w +: 16] = ($urandom_range(0, 4) == 0) ?
                                             16'd0 : 16'($urandom_range(1, 24));
            end
            span += int'(s.frame_windows[16*w +: 16]);
         end
         if (span > 65535) begin
            span = 65535;
         end
         s.mean_level = 16'($urandom_range(0, 65535) >> $urandom_range(0, 12));
         s.amplitude = 16'($urandom_range(0, 65535) >> $urandom_range(0, 12));
         s.spatial_steps = $urandom;
         s.time_phases = {16'($urandom), 16'($urandom), 16'($urandom)};
         s.colour_gains = {16'($urandom), 16'($urandom), 16'($urandom)};
         s.channel_phases = {16'($urandom), 16'($urandom), 16'($urandom)};
         apply_settings(s);
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 70; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 70; end
            default: begin send_idle_pct = 19; stall_pct = 19; end
         endcase
         repeat (90) begin
            if ($urandom_range(0, 9) == 0) begin
               t = 16'($urandom);
            end else begin
               t = 16'($urandom_range(0, span));
            end
            // a small pixel pool so that held frames read back written pixels
            if ($urandom_range(0, 1) == 1) begin
               x = 8'($urandom_range(0, 3) * 85);
               y = 8'($urandom_range(0, 3) * 85);
            end else begin
               x = 8'($urandom);
               y = 8'($urandom);
            end
            send_pixel(t, x, y);
         end
      end
   endtask

   task automatic test_output_holdoff();
      cfg_type s;
      s.grating_mode = MODE_DRIFT;
      s.frame_windows = 48'h0000_0020_0004;
      s.mean_level = 16'h0080;
      s.amplitude = 16'h0100;
      s.spatial_steps = 32'h0040_0100;
      s.time_phases = 48'h0000_0000_0123;
      s.colour_gains = 48'h8000_8000_8000;
      s.channel_phases = 48'h0000_5555_AAAA;
      apply_settings(s);
      send_idle_pct = 0;
      stall_pct = 0;
      holdoff_left = HOLDOFF_CYCLES;
      repeat (60) send_pixel(16'($urandom_range(0, 48)), 8'($urandom), 8'($urandom));
      drain_results();
   endtask

   task automatic test_sender_pause();
      send_idle_pct = 19;
      stall_pct = 19;
      for (int burst = 0; burst < 2; burst++) begin
         repeat (20) send_pixel(16'($urandom_range(0, 48)), 8'($urandom_range(0, 3)),
                                8'($urandom_range(0, 3)));
         drain_results();
      end
   endtask

   initial begin
      longint unsigned a;
      longint unsigned a2;
      longint unsigned term;
      longint          sum;
      // quarter-wave cosine, Q1.15, from a truncated taylor series
      for (int i = 0; i < QUARTER_N; i++) begin
         a = (QUARTER_TURN_Q30 * 64'(i)) >> COS_BITS;
         a2 = (a * a) >> 30;
         term = 64'd1 << 30;
         sum = longint'(term);
         for (int k = 1; k <= 7; k++) begin
            term = ((term * a2) >> 30) / 64'((2 * k - 1) * (2 * k));
            sum = (k % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
         end
         if (sum < 0) begin
            sum = 0;
         end
         quarter_wave[i] = int'((sum + 16384) >>> 15);
      end
      quarter_wave[QUARTER_N] = 0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_background_and_reversal();
      test_counterphase();
      test_window_overflow();
      test_drift_and_hold();
      test_random_settings();
      test_output_holdoff();
      test_sender_pause();

      repeat (DRAIN_TAIL) @(posedge clock);
      if (expected_pixels.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", expected_pixels.size()));
      end
      $display("covered %0d pixel transactions under %0d register settings, modes 0 to 3",
               pixels_sent, settings_written);
      $display("by window: %0d background, %0d grating, %0d reversed, %0d held from store",
               kind_count[KIND_BACKGROUND], kind_count[KIND_GRATING],
               kind_count[KIND_REVERSED], kind_count[KIND_HOLD]);
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/sgpg_pkg.sv
hw/rtl/sgpg_ram.sv
hw/rtl/sgpg_phase.sv
hw/rtl/sgpg_cos.sv
hw/rtl/sgpg_chan.sv
hw/rtl/sinusoidal_grating_pixel_generator.sv
tb/sv/sinusoidal_grating_pixel_generator_test.sv
